[rtl/core/pvm_pkg.sv]
// ----------------------------------------------------------------------------
// pvm_pkg: shared constants and helper functions of the PCM voice mixer
// Command codes, saturation limits and the helper functions used by the
// mixer core and its datapath.
// ----------------------------------------------------------------------------
package pvm_pkg;

    localparam logic [3:0] CMD_TICK      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;
    localparam logic [3:0] CMD_SETUP     = 4'd2;
    localparam logic [3:0] CMD_PLAY      = 4'd3;
    localparam logic [3:0] CMD_PLAY_SND  = 4'd4;
    localparam logic [3:0] CMD_STOP      = 4'd5;
    localparam logic [3:0] CMD_REWIND    = 4'd6;
    localparam logic [3:0] CMD_SET_LOOP  = 4'd7;
    localparam logic [3:0] CMD_SET_NEXT  = 4'd8;
    localparam logic [3:0] CMD_SET_GAIN  = 4'd9;
    localparam logic [3:0] CMD_DISPOSE   = 4'd10;
    localparam logic [3:0] CMD_CLEAR_ALL = 4'd11;
    localparam logic [3:0] CMD_STOP_ALL  = 4'd12;
    localparam logic [3:0] CMD_ALLOCATE  = 4'd13;
    localparam logic [3:0] CMD_QUERY     = 4'd14;
    localparam logic [3:0] CMD_MARK      = 4'd15;

    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN = -18'sd32768;

    // Signed sample times unsigned gain, divided by 32768 toward zero.
    function automatic logic signed [16:0] scale_sample(input logic signed [15:0] s,
                                                        input logic [15:0] g);
        logic signed [32:0] p;
        logic [32:0] mag;
        logic [17:0] q;
        p = $signed({{17{s[15]}}, s}) * $signed({17'd0, g});
        mag = p[32] ? 33'(-p) : 33'(p);
        q = mag[32:15];
        scale_sample = p[32] ? 17'(-$signed({1'b0, q[16:0]})) : $signed(q[16:0]);
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [16:0] b);
        logic signed [17:0] s;
        s = 18'(a) + 18'(b);
        if (s > SAT_MAX) begin
            sat_add = 16'sh7fff;
        end else if (s < SAT_MIN) begin
            sat_add = 16'sh8000;
        end else begin
            sat_add = s[15:0];
        end
    endfunction

endpackage

[rtl/core/pvm_ram.sv]
// ----------------------------------------------------------------------------
// pvm_ram: generic single-port RAM
// One access a cycle: an optional write and a read of the same address, with registered read data.
// ----------------------------------------------------------------------------
module pvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

[rtl/core/pvm_mac.sv]
// ----------------------------------------------------------------------------
// pvm_mac: shared scale and accumulate unit
// Scales one stereo frame by a voice gain and adds it into the running mix
// with saturation; the product is registered before the add.
// ----------------------------------------------------------------------------
module pvm_mac (
    input  logic               aclk,
    input  logic               clear,
    input  logic               mul_en,
    input  logic               acc_en,
    input  logic [31:0]        frame,
    input  logic [15:0]        gain,
    output logic signed [15:0] mix_l,
    output logic signed [15:0] mix_r
);
    import pvm_pkg::*;

    logic signed [16:0] prod_l_reg, prod_r_reg;
    logic signed [15:0] acc_l_reg, acc_r_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_l_reg <= scale_sample($signed(frame[15:0]), gain);
            prod_r_reg <= scale_sample($signed(frame[31:16]), gain);
        end
        if (clear) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (acc_en) begin
            acc_l_reg <= sat_add(acc_l_reg, prod_l_reg);
            acc_r_reg <= sat_add(acc_r_reg, prod_r_reg);
        end
    end

    assign mix_l = acc_l_reg;
    assign mix_r = acc_r_reg;
endmodule

[rtl/core/pcm_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// pcm_voice_mixer_core: multi-voice stereo PCM playback mixer
// Holds per-voice control state and a shared frame store, mixes one stereo
// output frame per tick word and executes voice control commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid/s_ready     cmd, voice, frame, samples, flags
//  m_        out        m_valid/m_ready     mix_left/right, voice_id, query
//  apb       in         psel/penable/pready master_gain at address 0
//
// A tick word walks all VOICES voices with one shared multiply/accumulate
// unit: a sounding voice goes through frame read, multiply and accumulate,
// a silent voice through the first step only; then follow a closing step,
// a start pass over all VOICES voices for chained voices and a done state
// that raises the tick result.
// Clear all and stop all sweep the voice table one entry per cycle;
// allocate scans the dynamic voices one per cycle; other commands act in
// the exec state and go straight on to the done state.
// The input is ready whenever the sequencer is idle. A finished word waits
// in the done state only while the previous result is still unaccepted.
// Reset clears all voice control state; the frame store is not cleared.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_core #(
    parameter int VOICES           = 32,
    parameter int DYNAMIC_BASE     = 16,
    parameter int FRAMES_PER_VOICE = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_cmd,
    input  logic [4:0]         s_voice,
    input  logic [9:0]         s_frame_index,
    input  logic signed [15:0] s_sample_left,
    input  logic signed [15:0] s_sample_right,
    input  logic               s_last_frame,
    input  logic               s_loop_flag,
    input  logic signed [5:0]  s_next_voice,
    input  logic [15:0]        s_gain,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mix_left,
    output logic signed [15:0] m_mix_right,
    output logic signed [5:0]  m_voice_id,
    output logic               m_is_playing,
    output logic               m_is_looping,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pvm_pkg::*;

    localparam int VW = $clog2(VOICES);
    localparam int FW = $clog2(FRAMES_PER_VOICE);
    localparam int PW = FW + 1;
    localparam int DEPTH = VOICES * FRAMES_PER_VOICE;
    localparam int AW = $clog2(DEPTH);
    localparam int DYN_COUNT = (DYNAMIC_BASE < VOICES) ? VOICES - DYNAMIC_BASE : 1;
    localparam logic HAS_DYN = DYNAMIC_BASE < VOICES;
    localparam logic [VW-1:0] DYN_BASE_V = HAS_DYN ? VW'(DYNAMIC_BASE) : '0;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_ALLOC = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Voice table in flip-flops: each entry is read at the walk index, at the
    // addressed voice or at the linked voice only.
    logic              alloc_reg [VOICES];
    logic              play_reg  [VOICES];
    logic              loop_reg  [VOICES];
    logic              start_reg [VOICES];
    logic signed [5:0] link_reg  [VOICES];
    logic [15:0]       gain_reg  [VOICES];
    logic [PW-1:0]     pos_reg   [VOICES];
    logic [PW-1:0]     len_reg   [VOICES];

    logic [2:0]        state_reg;
    logic [1:0]        phase_reg;
    logic [VW-1:0]     idx_reg;
    logic [VW:0]       cnt_reg;
    logic [VW-1:0]     aptr_reg;
    logic [15:0]       master_reg;
    logic [3:0]        cmd_reg;
    logic [4:0]        voice_reg;
    logic [9:0]        fi_reg;
    logic [31:0]       smp_reg;
    logic              last_reg, lflag_reg;
    logic signed [5:0] next_reg;
    logic [31:0]       gprod_reg;
    logic              mac_acc_reg;

    logic               m_valid_reg;
    logic signed [15:0] out_l_reg, out_r_reg;
    logic signed [5:0]  out_id_reg;
    logic               out_p_reg, out_lp_reg;
    logic signed [15:0] m_left_reg, m_right_reg;
    logic signed [5:0]  m_id_reg;
    logic               m_play_reg, m_loop_reg;

    logic              vvalid;
    logic [VW-1:0]     vidx;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [31:0]       ram_rdata;
    logic              mac_clear, mac_mul;
    logic signed [15:0] mix_l, mix_r;
    logic [PW-1:0]     wpos;
    logic              wsound;
    logic signed [6:0] wlink;
    logic [VW-1:0]     lidx;
    logic              link_ok;
    logic [VW-1:0]     anext;
    logic [2:0]        exec_next;

    assign vvalid = 32'(voice_reg) < VOICES;
    assign vidx   = VW'(voice_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign pready = 1'b1;
    assign prdata = {16'd0, master_reg};

    // Walking voice: position after a possible loop wrap.
    assign wpos = (pos_reg[idx_reg] >= len_reg[idx_reg]) ? '0 : pos_reg[idx_reg];
    assign wsound = play_reg[idx_reg] && (len_reg[idx_reg] != '0) &&
                    ((pos_reg[idx_reg] < len_reg[idx_reg]) || loop_reg[idx_reg]);
    assign wlink = 7'(link_reg[idx_reg]);
    assign lidx = VW'(wlink[5:0]);
    assign link_ok = (wlink >= 0) && (32'(wlink) < VOICES) &&
                     alloc_reg[lidx] && (len_reg[lidx] != '0);
    // Next candidate of the allocation scan, wrapping inside the dynamic range.
    assign anext = (32'(idx_reg) + 1 < VOICES) ? idx_reg + VW'(1) : DYN_BASE_V;

    always_comb begin
        case (cmd_reg)
            CMD_TICK:      exec_next = ST_WALK;
            CMD_CLEAR_ALL: exec_next = ST_SWEEP;
            CMD_STOP_ALL:  exec_next = ST_SWEEP;
            CMD_ALLOCATE:  exec_next = HAS_DYN ? ST_ALLOC : ST_DONE;
            default:       exec_next = ST_DONE;
        endcase
    end

    always_comb begin
        ram_we = (state_reg == ST_EXEC) && (cmd_reg == CMD_LOAD) && vvalid &&
                 (32'(fi_reg) < FRAMES_PER_VOICE);
        if (state_reg == ST_WALK) begin
            ram_addr = AW'(32'(idx_reg) * FRAMES_PER_VOICE + 32'(wpos));
        end else begin
            ram_addr = AW'(32'(vidx) * FRAMES_PER_VOICE + 32'(fi_reg));
        end
    end

    assign mac_clear = (state_reg == ST_IDLE);
    assign mac_mul = (state_reg == ST_WALK) && (phase_reg == 2'd1);

    pvm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .aclk (aclk), .we (ram_we), .addr (ram_addr), .wdata (smp_reg),
        .rdata(ram_rdata)
    );

    pvm_mac u_mac (
        .aclk(aclk), .clear(mac_clear), .mul_en(mac_mul), .acc_en(mac_acc_reg),
        .frame(ram_rdata), .gain(gain_reg[idx_reg]), .mix_l(mix_l), .mix_r(mix_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg <= UNITY_GAIN;
        end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
            master_reg <= pwdata[15:0];
        end
    end

    // The gain product is formed as the word is taken, so it is ready when
    // the set gain command executes.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            voice_reg <= s_voice;
            fi_reg    <= s_frame_index;
            smp_reg   <= {s_sample_right, s_sample_left};
            last_reg  <= s_last_frame;
            lflag_reg <= s_loop_flag;
            next_reg  <= s_next_voice;
            gprod_reg <= s_gain * master_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            aptr_reg    <= DYN_BASE_V;
            m_valid_reg <= 1'b0;
            mac_acc_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                alloc_reg[i] <= 1'b0;
                play_reg[i]  <= 1'b0;
                loop_reg[i]  <= 1'b0;
                start_reg[i] <= 1'b0;
                link_reg[i]  <= -6'sd1;
                gain_reg[i]  <= UNITY_GAIN;
                pos_reg[i]   <= '0;
                len_reg[i]   <= '0;
            end
        end else begin
            mac_acc_reg <= mac_mul;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg  <= ST_EXEC;
                        idx_reg    <= '0;
                        cnt_reg    <= '0;
                        phase_reg  <= '0;
                        out_l_reg  <= '0;
                        out_r_reg  <= '0;
                        out_id_reg <= '0;
                        out_p_reg  <= 1'b0;
                        out_lp_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    state_reg <= exec_next;
                    case (cmd_reg)
                        CMD_TICK: begin
                        end
                        CMD_LOAD: begin
                            if (vvalid && 32'(fi_reg) < FRAMES_PER_VOICE && last_reg) begin
                                len_reg[vidx] <= PW'(fi_reg) + PW'(1);
                            end
                        end
                        CMD_SETUP: begin
                            if (vvalid) begin
                                alloc_reg[vidx] <= 1'b1;
                                play_reg[vidx]  <= 1'b0;
                                loop_reg[vidx]  <= lflag_reg;
                                pos_reg[vidx]   <= '0;
                            end
                        end
                        CMD_PLAY: begin
                            if (vvalid && alloc_reg[vidx]) begin
                                play_reg[vidx] <= 1'b1;
                                if (pos_reg[vidx] >= len_reg[vidx]) begin
                                    pos_reg[vidx] <= '0;
                                end
                            end
                        end
                        CMD_PLAY_SND: begin
                            if (vvalid && alloc_reg[vidx]) begin
                                play_reg[vidx] <= 1'b1;
                                loop_reg[vidx] <= lflag_reg;
                                pos_reg[vidx]  <= '0;
                            end
                        end
                        CMD_STOP: if (vvalid) play_reg[vidx] <= 1'b0;
                        CMD_REWIND: if (vvalid) pos_reg[vidx] <= '0;
                        CMD_SET_LOOP: if (vvalid) loop_reg[vidx] <= lflag_reg;
                        CMD_SET_NEXT: if (vvalid) link_reg[vidx] <= next_reg;
                        CMD_SET_GAIN: begin
                            if (vvalid) begin
                                gain_reg[vidx] <= (gprod_reg[31:15] > 17'd65535) ?
                                                  16'hffff : gprod_reg[30:15];
                            end
                        end
                        CMD_DISPOSE: begin
                            if (vvalid) begin
                                alloc_reg[vidx] <= 1'b0;
                                play_reg[vidx]  <= 1'b0;
                                loop_reg[vidx]  <= 1'b0;
                                link_reg[vidx]  <= -6'sd1;
                                gain_reg[vidx]  <= UNITY_GAIN;
                                pos_reg[vidx]   <= '0;
                                len_reg[vidx]   <= '0;
                            end
                        end
                        CMD_CLEAR_ALL: aptr_reg <= DYN_BASE_V;
                        CMD_STOP_ALL: begin
                        end
                        CMD_ALLOCATE: begin
                            // The scan starts at the round-robin pointer.
                            idx_reg <= aptr_reg;
                            if (!HAS_DYN) begin
                                out_id_reg <= -6'sd1;
                            end
                        end
                        CMD_QUERY: begin
                            if (vvalid) begin
                                out_p_reg  <= play_reg[vidx];
                                out_lp_reg <= alloc_reg[vidx] && loop_reg[vidx];
                            end
                        end
                        default: if (vvalid) alloc_reg[vidx] <= 1'b1;
                    endcase
                end
                ST_WALK: begin
                    // Phase 0 settles the voice and reads its frame; phase 1
                    // multiplies; phase 2 lets the accumulate land.
                    case (phase_reg)
                        2'd0: begin
                            if (play_reg[idx_reg] && len_reg[idx_reg] != '0 &&
                                pos_reg[idx_reg] >= len_reg[idx_reg] &&
                                !loop_reg[idx_reg]) begin
                                play_reg[idx_reg] <= 1'b0;
                                if (link_ok) start_reg[lidx] <= 1'b1;
                            end
                            if (wsound) begin
                                pos_reg[idx_reg] <= wpos + PW'(1);
                                phase_reg <= 2'd1;
                            end else if (32'(idx_reg) == VOICES - 1) begin
                                phase_reg <= 2'd3;
                            end else begin
                                idx_reg <= idx_reg + VW'(1);
                            end
                        end
                        2'd1: phase_reg <= 2'd2;
                        2'd2: begin
                            if (32'(idx_reg) == VOICES - 1) begin
                                phase_reg <= 2'd3;
                            end else begin
                                idx_reg   <= idx_reg + VW'(1);
                                phase_reg <= 2'd0;
                            end
                        end
                        default: begin
                            state_reg <= ST_START;
                            idx_reg   <= '0;
                        end
                    endcase
                end
                ST_START: begin
                    if (start_reg[idx_reg]) begin
                        start_reg[idx_reg] <= 1'b0;
                        pos_reg[idx_reg]   <= '0;
                        play_reg[idx_reg]  <= 1'b1;
                    end
                    if (32'(idx_reg) == VOICES - 1) begin
                        out_l_reg <= mix_l;
                        out_r_reg <= mix_r;
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                ST_SWEEP: begin
                    play_reg[idx_reg] <= 1'b0;
                    if (cmd_reg == CMD_CLEAR_ALL) begin
                        alloc_reg[idx_reg] <= 1'b0;
                        loop_reg[idx_reg]  <= 1'b0;
                        link_reg[idx_reg]  <= -6'sd1;
                        gain_reg[idx_reg]  <= UNITY_GAIN;
                        pos_reg[idx_reg]   <= '0;
                        len_reg[idx_reg]   <= '0;
                    end
                    if (32'(idx_reg) == VOICES - 1) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                ST_ALLOC: begin
                    if (!alloc_reg[idx_reg]) begin
                        alloc_reg[idx_reg] <= 1'b1;
                        aptr_reg   <= anext;
                        out_id_reg <= 6'(idx_reg);
                        state_reg  <= ST_DONE;
                    end else if (32'(cnt_reg) == DYN_COUNT - 1) begin
                        out_id_reg <= -6'sd1;
                        state_reg  <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + (VW+1)'(1);
                        idx_reg <= anext;
                    end
                end
                ST_DONE: begin
                    // Hand the result over once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_left_reg  <= out_l_reg;
                        m_right_reg <= out_r_reg;
                        m_id_reg    <= out_id_reg;
                        m_play_reg  <= out_p_reg;
                        m_loop_reg  <= out_lp_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mix_left   = m_left_reg;
    assign m_mix_right  = m_right_reg;
    assign m_voice_id   = m_id_reg;
    assign m_is_playing = m_play_reg;
    assign m_is_looping = m_loop_reg;

    // A result that waits keeps its data until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_left_reg) &&
        $stable(m_right_reg) && $stable(m_id_reg)))
        else $error("pending result changed");
    // A result is raised only from the final state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");
    // The allocation pointer stays inside the dynamic range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !HAS_DYN || (32'(aptr_reg) >= DYNAMIC_BASE)) else $error("pointer out of range");
endmodule

[sim/pcm_voice_mixer_core_tb.sv]
// ----------------------------------------------------------------------------
// pcm_voice_mixer_core_tb: self-checking bench of the PCM voice mixer core
// Drives command words into the mixer and predicts every result word from a
// behavioral model of the voice table and frame store kept in the bench. The
// run covers directed cases, random command streams under several idling
// phases, a long receiver hold-off and master gain changes done while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pcm_voice_mixer_core_tb;
    import pvm_pkg::*;

    localparam int NV = 32;
    localparam int DYN = 16;
    localparam int FPV = 1024;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [5:0]  id;
        logic               playing;
        logic               looping;
    } mix_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0] s_cmd = '0;
    logic [4:0] s_voice = '0;
    logic [9:0] s_frame_index = '0;
    logic signed [15:0] s_sample_left = '0;
    logic signed [15:0] s_sample_right = '0;
    logic s_last_frame = 1'b0;
    logic s_loop_flag = 1'b0;
    logic signed [5:0] s_next_voice = '0;
    logic [15:0] s_gain = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_mix_left;
    logic signed [15:0] m_mix_right;
    logic signed [5:0] m_voice_id;
    logic m_is_playing;
    logic m_is_looping;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pcm_voice_mixer_core dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model state of the mixer.
    logic [15:0] mdl_master;
    logic        mdl_alloc [NV];
    logic        mdl_play [NV];
    logic        mdl_loop [NV];
    int          mdl_link [NV];
    logic [15:0] mdl_gain [NV];
    int          mdl_pos [NV];
    int          mdl_len [NV];
    logic [31:0] mdl_frames [NV*FPV];
    logic        mdl_written [NV*FPV];
    int          mdl_ptr;

    mix_result_t expected_words[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct_send = 0;
    int idle_pct_recv = 0;
    bit hold_recv = 1'b0;

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("ERROR %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic void clear_voice(input int v);
        mdl_alloc[v] = 0;
        mdl_play[v] = 0;
        mdl_loop[v] = 0;
        mdl_link[v] = -1;
        mdl_gain[v] = UNITY_GAIN;
        mdl_pos[v] = 0;
        mdl_len[v] = 0;
    endfunction

    function automatic int scaled(input logic signed [15:0] s, input logic [15:0] g);
        longint p;
        p = longint'(s) * longint'(g);
        return (p < 0) ? -int'((-p) >>> 15) : int'(p >>> 15);
    endfunction

    function automatic int clip16(input int x);
        return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
    endfunction

    // Applies one command word to the model and returns the result word.
    function automatic mix_result_t mixer_predict(input logic [3:0] cmd, input int v,
            input int fi, input logic [15:0] sl, input logic [15:0] sr,
            input logic last, input logic lp, input logic signed [5:0] nx,
            input logic [15:0] g);
        mix_result_t r;
        bit starts [NV];
        int l, rr, n, cnt, id;
        logic [31:0] fr;
        longint prod;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                l = 0;
                rr = 0;
                foreach (starts[i]) starts[i] = 0;
                for (int i = 0; i < NV; i++) begin
                    if (!mdl_play[i] || mdl_len[i] == 0) continue;
                    if (mdl_pos[i] >= mdl_len[i]) begin
                        if (mdl_loop[i]) begin
                            mdl_pos[i] = 0;
                        end else begin
                            n = mdl_link[i];
                            mdl_play[i] = 0;
                            if (n >= 0 && n < NV && mdl_alloc[n] && mdl_len[n] != 0)
                                starts[n] = 1;
                            continue;
                        end
                    end
                    fr = mdl_frames[i*FPV + mdl_pos[i]];
                    l = clip16(l + scaled(fr[15:0], mdl_gain[i]));
                    rr = clip16(rr + scaled(fr[31:16], mdl_gain[i]));
                    mdl_pos[i]++;
                end
                for (int i = 0; i < NV; i++) begin
                    if (starts[i]) begin
                        mdl_pos[i] = 0;
                        mdl_play[i] = 1;
                    end
                end
                r.left = 16'(l);
                r.right = 16'(rr);
            end
            CMD_LOAD: begin
                mdl_frames[v*FPV + fi] = {sr, sl};
                mdl_written[v*FPV + fi] = 1;
                if (last) mdl_len[v] = fi + 1;
            end
            CMD_SETUP: begin
                mdl_alloc[v] = 1;
                mdl_play[v] = 0;
                mdl_loop[v] = lp;
                mdl_pos[v] = 0;
            end
            CMD_PLAY: begin
                if (mdl_alloc[v]) begin
                    mdl_play[v] = 1;
                    if (mdl_pos[v] >= mdl_len[v]) mdl_pos[v] = 0;
                end
            end
            CMD_PLAY_SND: begin
                if (mdl_alloc[v]) begin
                    mdl_play[v] = 1;
                    mdl_loop[v] = lp;
                    mdl_pos[v] = 0;
                end
            end
            CMD_STOP: mdl_play[v] = 0;
            CMD_REWIND: mdl_pos[v] = 0;
            CMD_SET_LOOP: mdl_loop[v] = lp;
            CMD_SET_NEXT: mdl_link[v] = int'(nx);
            CMD_SET_GAIN: begin
                prod = (longint'(g) * longint'(mdl_master)) >>> 15;
                mdl_gain[v] = prod > 65535 ? 16'hffff : 16'(prod);
            end
            CMD_DISPOSE: clear_voice(v);
            CMD_CLEAR_ALL: begin
                for (int i = 0; i < NV; i++) clear_voice(i);
                mdl_ptr = DYN;
            end
            CMD_STOP_ALL: for (int i = 0; i < NV; i++) mdl_play[i] = 0;
            CMD_ALLOCATE: begin
                id = -1;
                cnt = NV - DYN;
                for (int i = 0; i < cnt; i++) begin
                    n = DYN + ((mdl_ptr - DYN + i) % cnt);
                    if (!mdl_alloc[n]) begin
                        mdl_alloc[n] = 1;
                        mdl_ptr = (n + 1 < NV) ? n + 1 : DYN;
                        id = n;
                        break;
                    end
                end
                r.id = 6'(id);
            end
            CMD_QUERY: begin
                r.playing = mdl_play[v];
                r.looping = mdl_alloc[v] & mdl_loop[v];
            end
            default: mdl_alloc[v] = 1;
        endcase
        return r;
    endfunction

    // A tick may only read frames that were loaded. Returns 1 when safe.
    function automatic bit tick_is_safe();
        for (int i = 0; i < NV; i++) begin
            if (!mdl_play[i] || mdl_len[i] == 0) continue;
            if (mdl_pos[i] < mdl_len[i]) begin
                if (!mdl_written[i*FPV + mdl_pos[i]]) return 0;
            end else if (mdl_loop[i] && !mdl_written[i*FPV]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    // Sends one word; the expectation is queued at acceptance. Valid stays
    // high afterwards so the next word can follow without a gap; idle gaps
    // and drain drop it.
    task automatic send_word(input logic [3:0] cmd, input int v, input int fi = 0,
            input logic [15:0] sl = 0, input logic [15:0] sr = 0,
            input logic last = 0, input logic lp = 0,
            input logic signed [5:0] nx = -1, input logic [15:0] g = UNITY_GAIN);
        while ($urandom_range(99) < idle_pct_send) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_cmd <= cmd;
        s_voice <= 5'(v);
        s_frame_index <= 10'(fi);
        s_sample_left <= sl;
        s_sample_right <= sr;
        s_last_frame <= last;
        s_loop_flag <= lp;
        s_next_voice <= nx;
        s_gain <= g;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(mixer_predict(cmd, v, fi, sl, sr, last, lp, nx, g));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (4 * NV + 20) @(negedge aclk);
    endtask

    task automatic write_master(input logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        mdl_master = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Loads a voice with a short random sample of len frames.
    task automatic load_voice(input int v, input int len);
        for (int f = 0; f < len; f++)
            send_word(CMD_LOAD, v, f, 16'($urandom), 16'($urandom), f == len - 1);
    endtask

    // Receiver: stalls at random or during a hold-off, checks each word.
    always @(negedge aclk) begin
        m_ready <= !hold_recv && ($urandom_range(99) >= idle_pct_recv);
    end

    always @(posedge aclk) begin
        mix_result_t w;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                w = expected_words.pop_front();
                if (m_mix_left !== w.left) report("mix_left", m_mix_left, w.left);
                if (m_mix_right !== w.right) report("mix_right", m_mix_right, w.right);
                if (m_voice_id !== w.id) report("voice_id", m_voice_id, w.id);
                if (m_is_playing !== w.playing)
                    report("is_playing", m_is_playing, w.playing);
                if (m_is_looping !== w.looping)
                    report("is_looping", m_is_looping, w.looping);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("pcm_voice_mixer_core: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        // Extreme samples on two voices, one at full gain so the sum saturates and one at zero gain.
        send_word(CMD_SETUP, 0, 0, 0, 0, 0, 1);
        send_word(CMD_LOAD, 0, 0, 16'h7fff, 16'h8000, 1);
        send_word(CMD_SETUP, 1, 0, 0, 0, 0, 0);
        send_word(CMD_LOAD, 1, 0, 16'h7fff, 16'h8000);
        send_word(CMD_LOAD, 1, 1, 16'h0001, 16'hffff, 1);
        // A load past the frame range of the voice does not exist here, since
        // the index field tops out at the last frame; the top index is used.
        send_word(CMD_LOAD, 2, FPV - 1, 16'h1234, 16'h8765, 1);
        send_word(CMD_SET_GAIN, 0, 0, 0, 0, 0, 0, -1, 16'hffff);
        send_word(CMD_SET_GAIN, 1, 0, 0, 0, 0, 0, -1, 16'h0000);
        send_word(CMD_SET_NEXT, 1, 0, 0, 0, 0, 0, 6'sd0);
        send_word(CMD_PLAY, 0);
        send_word(CMD_PLAY_SND, 1, 0, 0, 0, 0, 0);
        send_word(CMD_PLAY, 5);  // not allocated, so nothing starts
        send_word(CMD_TICK, 0);
        send_word(CMD_TICK, 0);
        send_word(CMD_TICK, 0);
        send_word(CMD_QUERY, 1);
        send_word(CMD_SET_LOOP, 0, 0, 0, 0, 0, 0);
        send_word(CMD_TICK, 0);
        send_word(CMD_TICK, 0);
        send_word(CMD_QUERY, 0);
        send_word(CMD_MARK, 3);
        send_word(CMD_PLAY, 3);  // empty voice is skipped by the tick
        send_word(CMD_TICK, 0);
        send_word(CMD_REWIND, 1);
        send_word(CMD_STOP, 3);
        send_word(CMD_STOP_ALL, 0);
        send_word(CMD_DISPOSE, 0);
        send_word(CMD_QUERY, 0);
        // Exhaust the dynamic voices, then ask once more.
        for (int i = 0; i <= NV - DYN; i++) send_word(CMD_ALLOCATE, 0);
        send_word(CMD_CLEAR_ALL, 0);
        send_word(CMD_ALLOCATE, 0);
        drain();
    endtask

    // Random command stream: mostly well-formed playback with random content.
    task automatic test_random(input int count);
        int c, v;
        logic [3:0] cmd;
        for (int n = 0; n < count; n++) begin
            v = $urandom_range(NV - 1);
            c = $urandom_range(99);
            if (c < 30) begin
                if (tick_is_safe()) send_word(CMD_TICK, 0);
                else send_word(CMD_QUERY, v);
            end else if (c < 45) begin
                send_word(CMD_LOAD, v, $urandom_range(7), 16'($urandom), 16'($urandom),
                          $urandom_range(3) == 0);
            end else begin
                cmd = 4'($urandom_range(1, 15));
                if (cmd == CMD_LOAD) cmd = CMD_QUERY;
                send_word(cmd, v, 0, 0, 0, 0, 1'($urandom),
                          6'($urandom_range(0, 33) - 1), 16'($urandom));
            end
        end
    endtask

    // Builds a few looping and chained voices so ticks mix real data.
    task automatic build_voices();
        for (int v = 0; v < 6; v++) begin
            load_voice(v, $urandom_range(1, 6));
            send_word(CMD_SETUP, v, 0, 0, 0, 0, 1'($urandom));
            send_word(CMD_SET_GAIN, v, 0, 0, 0, 0, 0, -1, 16'($urandom));
            send_word(CMD_SET_NEXT, v, 0, 0, 0, 0, 0, 6'((v + 1) % 6));
        end
        send_word(CMD_PLAY, 0);
        send_word(CMD_PLAY_SND, 3, 0, 0, 0, 0, 0);
    endtask

    task automatic test_phases();
        int send_pct [4] = '{0, 74, 0, 8};
        int recv_pct [4] = '{0, 0, 74, 8};
        logic [15:0] gains [4] = '{16'h8000, 16'h0000, 16'hffff, 16'h4000};
        for (int p = 0; p < 4; p++) begin
            write_master(p == 3 ? 16'($urandom) : gains[p]);
            idle_pct_send = send_pct[p];
            idle_pct_recv = recv_pct[p];
            build_voices();
            test_random(45);
            idle_pct_send = 0;
            drain();
        end
        idle_pct_recv = 0;
    endtask

    // Receiver holds off while words keep coming, filling the block.
    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(negedge aclk);
                hold_recv = 1'b0;
            end
            test_random(20);
        join
        drain();
        write_master(UNITY_GAIN);
        test_random(40);
    endtask

    initial begin
        for (int i = 0; i < NV; i++) clear_voice(i);
        foreach (mdl_written[i]) mdl_written[i] = 0;
        mdl_master = UNITY_GAIN;
        mdl_ptr = DYN;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_phases();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("pcm_voice_mixer_core: match");
        end else begin
            $display("pcm_voice_mixer_core: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pvm_pkg.sv
rtl/core/pvm_ram.sv
rtl/core/pvm_mac.sv
rtl/core/pcm_voice_mixer_core.sv
sim/pcm_voice_mixer_core_tb.sv
